// ===== hdl/bale_pkg.sv =====
// Package for the bounded array list engine: command and status codes,
// default capacity and field widths. No dependencies.
`default_nettype none
package bale_pkg;
   localparam int CAPACITY_DEF = 64;
   localparam int CMD_W  = 4;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT_AT   = 4'd0;
   localparam logic [CMD_W-1:0] CMD_SORTED_INS  = 4'd1;
   localparam logic [CMD_W-1:0] CMD_FIND_DEL    = 4'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE_AT   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_BLANK_EQ    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_BLANK_DUPS  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_REVERSE     = 4'd6;
   localparam logic [CMD_W-1:0] CMD_CLEAR       = 4'd7;
   localparam logic [CMD_W-1:0] CMD_READ        = 4'd8;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

   // memory operations issued by the controller
   localparam logic [2:0] MOP_NONE  = 3'd0;
   localparam logic [2:0] MOP_RDA   = 3'd1; // read addr a into rd_a
   localparam logic [2:0] MOP_RDB   = 3'd2; // read addr b into rd_b
   localparam logic [2:0] MOP_WRV   = 3'd3; // write value to addr a
   localparam logic [2:0] MOP_WRA   = 3'd4; // write rd_a to addr b
   localparam logic [2:0] MOP_WRB   = 3'd5; // write rd_b to addr a
   localparam logic [2:0] MOP_WRZ   = 3'd6; // write zero to addr a

   typedef struct packed {
      logic [2:0]  mop;
      logic [10:0] addr_a;
      logic [10:0] addr_b;
   } mem_cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] rd_a;
      logic [DATA_W-1:0] rd_b;
   } mem_stat_type;
endpackage
`default_nettype wire

// ===== hdl/bale_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on bale_pkg.
`default_nettype none
interface bale_req_if;
   logic valid;
   logic ready;
   logic [bale_pkg::CMD_W-1:0]  command;
   logic [bale_pkg::POS_W-1:0]  position;
   logic signed [bale_pkg::DATA_W-1:0] value;
   modport source (output valid, command, position, value, input ready);
   modport sink   (input valid, command, position, value, output ready);
endinterface

interface bale_rsp_if;
   logic valid;
   logic ready;
   logic [bale_pkg::STAT_W-1:0] status;
   logic [bale_pkg::POS_W-1:0]  slot;
   logic signed [bale_pkg::DATA_W-1:0] read_value;
   logic [bale_pkg::POS_W-1:0]  count;
   modport source (output valid, status, slot, read_value, count, input ready);
   modport sink   (input valid, status, slot, read_value, count, output ready);
endinterface
`default_nettype wire

// ===== hdl/bounded_array_list_engine.sv =====
// Top level of the bounded array list engine: controller plus list store.
// Depends on bale_pkg, bale_if, bale_controller and bale_datapath.
`default_nettype none
// One command in, one response out, one at a time. The list lives in a
// single-port memory of CAPACITY words, accessed once per cycle: shifts for
// inserts and deletes read and write each moved entry; searches read each
// entry examined; reverse reads and writes both entries of each swapped
// pair; duplicate blanking examines pairs (order of count squared). No
// clearing pass is needed after reset.
module bounded_array_list_engine #(
   parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
   input wire logic clock,
   input wire logic reset,
   bale_req_if.sink   req,
   bale_rsp_if.source rsp
);
   bale_pkg::mem_cmd_type mcmd;
   bale_pkg::mem_stat_type mstat;
   logic [bale_pkg::DATA_W-1:0] wr_value;

   bale_controller #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock, .reset, .req, .rsp, .mcmd, .wr_value, .mstat
   );
   bale_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock, .cmd(mcmd), .wr_value, .stat(mstat)
   );
endmodule
`default_nettype wire

// ===== hdl/bale_datapath.sv =====
// List store memory with registered read ports, driven by controller commands.
// Depends on bale_pkg.
`default_nettype none
module bale_datapath #(
   parameter int CAPACITY = bale_pkg::CAPACITY_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic clock,
   input  wire bale_pkg::mem_cmd_type cmd,
   input  wire logic [bale_pkg::DATA_W-1:0] wr_value,
   output bale_pkg::mem_stat_type stat
);
   logic [bale_pkg::DATA_W-1:0] mem [CAPACITY];
   logic [bale_pkg::DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0] aa, ab;

   assign aa = cmd.addr_a[AW-1:0];
   assign ab = cmd.addr_b[AW-1:0];

   always_ff @(posedge clock) begin
      case (cmd.mop)
         bale_pkg::MOP_RDA: rd_a_ff <= mem[aa];
         bale_pkg::MOP_RDB: rd_b_ff <= mem[ab];
         bale_pkg::MOP_WRV: mem[aa] <= wr_value;
         bale_pkg::MOP_WRA: mem[ab] <= rd_a_ff;
         bale_pkg::MOP_WRB: mem[aa] <= rd_b_ff;
         bale_pkg::MOP_WRZ: mem[aa] <= '0;
         default: ;
      endcase
   end

   assign stat.rd_a = rd_a_ff;
   assign stat.rd_b = rd_b_ff;
endmodule
`default_nettype wire

// ===== hdl/bale_controller.sv =====
// Command sequencer: walks the list one memory access per cycle and forms
// the result. Depends on bale_pkg; drives bale_datapath.
`default_nettype none
module bale_controller #(
   parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   bale_req_if.sink   req,
   bale_rsp_if.source rsp,
   output bale_pkg::mem_cmd_type mcmd,
   output logic [bale_pkg::DATA_W-1:0] wr_value,
   input  wire bale_pkg::mem_stat_type mstat
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_SRD   = 4'd2;  // search: read i
   localparam logic [3:0] S_SCMP  = 4'd3;  // search: compare rd_a
   localparam logic [3:0] S_UPRD  = 4'd4;  // shift up: read j-1
   localparam logic [3:0] S_UPWR  = 4'd5;  // shift up: write j
   localparam logic [3:0] S_PUT   = 4'd6;
   localparam logic [3:0] S_DNRD  = 4'd7;  // shift down: read j+1
   localparam logic [3:0] S_DNWR  = 4'd8;
   localparam logic [3:0] S_RVB   = 4'd9;  // reverse: read j
   localparam logic [3:0] S_RVW   = 4'd10; // reverse: cross writes
   localparam logic [3:0] S_RVW2  = 4'd11;
   localparam logic [3:0] S_DPB   = 4'd12; // dups: compare rd_b vs rd_a
   localparam logic [3:0] S_RDWT  = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;
   localparam logic [3:0] S_RVA   = 4'd15; // reverse: read i

   localparam int CW = $clog2(CAPACITY + 1) + 1;

   logic [3:0] state_ff, state_in;
   logic [bale_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [bale_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [bale_pkg::DATA_W-1:0] val_ff, val_in;
   logic [CW-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in;
   logic [bale_pkg::STAT_W-1:0] st_ff, st_in;
   logic [bale_pkg::POS_W-1:0] slot_ff, slot_in;
   logic [bale_pkg::DATA_W-1:0] rdv_ff, rdv_in;
   logic dupb_ff, dupb_in; // dups: rd_b holds item at j, rd_a item i

   logic [CW-1:0] posx;
   logic signed [bale_pkg::DATA_W-1:0] sa, sv;

   assign posx = CW'(pos_ff);
   assign sa = mstat.rd_a;
   assign sv = val_ff;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_DONE);
   assign rsp.status = st_ff;
   assign rsp.slot = slot_ff;
   assign rsp.read_value = rdv_ff;
   assign rsp.count = cnt_ff[bale_pkg::POS_W-1:0];
   assign wr_value = val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      cmd_ff <= cmd_in; pos_ff <= pos_in; val_ff <= val_in;
      i_ff <= i_in; j_ff <= j_in; st_ff <= st_in; slot_ff <= slot_in;
      rdv_ff <= rdv_in; dupb_ff <= dupb_in;
   end

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; pos_in = pos_ff; val_in = val_ff;
      cnt_in = cnt_ff; i_in = i_ff; j_in = j_ff; st_in = st_ff;
      slot_in = slot_ff; rdv_in = rdv_ff; dupb_in = dupb_ff;
      mcmd.mop = bale_pkg::MOP_NONE;
      mcmd.addr_a = 11'(i_ff);
      mcmd.addr_b = 11'(j_ff);
      case (state_ff)
         S_IDLE: if (req.valid) begin
            cmd_in = req.command; pos_in = req.position; val_in = req.value;
            st_in = bale_pkg::ST_OK; slot_in = '0; rdv_in = '0;
            state_in = S_DISP;
         end
         S_DISP: begin
            i_in = '0;
            state_in = S_DONE;
            case (cmd_ff)
               bale_pkg::CMD_INSERT_AT:
                  if (posx < CW'(1) || posx > cnt_ff + CW'(1)) st_in = bale_pkg::ST_BAD;
                  else if (cnt_ff >= CW'(CAPACITY)) st_in = bale_pkg::ST_FULL;
                  else begin
                     i_in = posx - CW'(1); j_in = cnt_ff; state_in = S_UPRD;
                  end
               bale_pkg::CMD_SORTED_INS:
                  if (cnt_ff >= CW'(CAPACITY)) st_in = bale_pkg::ST_FULL;
                  else state_in = S_SRD;
               bale_pkg::CMD_FIND_DEL, bale_pkg::CMD_BLANK_EQ: begin
                  if (cmd_ff == bale_pkg::CMD_BLANK_EQ) st_in = bale_pkg::ST_BAD;
                  state_in = S_SRD;
               end
               bale_pkg::CMD_DELETE_AT:
                  if (posx < CW'(1) || posx > cnt_ff) st_in = bale_pkg::ST_BAD;
                  else begin j_in = posx - CW'(1); state_in = S_DNRD; end
               bale_pkg::CMD_BLANK_DUPS: state_in = S_SRD;
               bale_pkg::CMD_REVERSE:
                  if (cnt_ff > CW'(1)) begin j_in = cnt_ff - CW'(1); state_in = S_RVA; end
               bale_pkg::CMD_CLEAR: cnt_in = '0;
               bale_pkg::CMD_READ:
                  if (posx < CW'(1) || posx > cnt_ff) st_in = bale_pkg::ST_BAD;
                  else begin
                     mcmd.mop = bale_pkg::MOP_RDA;
                     mcmd.addr_a = 11'(posx - CW'(1));
                     state_in = S_RDWT;
                  end
               default: st_in = bale_pkg::ST_BAD;
            endcase
         end
         S_RDWT: begin rdv_in = mstat.rd_a; state_in = S_DONE; end
         S_SRD: begin
            if (i_ff < cnt_ff) begin
               mcmd.mop = bale_pkg::MOP_RDA; state_in = S_SCMP;
            end else begin
               state_in = S_DONE;
               case (cmd_ff)
                  bale_pkg::CMD_SORTED_INS: begin
                     slot_in = bale_pkg::POS_W'(i_ff); j_in = cnt_ff; state_in = S_UPRD;
                  end
                  bale_pkg::CMD_FIND_DEL: st_in = bale_pkg::ST_BAD;
                  default: ;
               endcase
            end
         end
         S_SCMP: begin
            state_in = S_SRD; i_in = i_ff + CW'(1);
            case (cmd_ff)
               bale_pkg::CMD_SORTED_INS:
                  if (!(sa < sv)) begin
                     slot_in = bale_pkg::POS_W'(i_ff); j_in = cnt_ff; i_in = i_ff;
                     state_in = S_UPRD;
                  end
               bale_pkg::CMD_FIND_DEL:
                  if (mstat.rd_a == val_ff) begin
                     slot_in = bale_pkg::POS_W'(i_ff + CW'(1)); j_in = i_ff;
                     state_in = S_DNRD;
                  end
               bale_pkg::CMD_BLANK_EQ:
                  if (mstat.rd_a == val_ff) begin
                     mcmd.mop = bale_pkg::MOP_WRZ; st_in = bale_pkg::ST_OK;
                  end
               default: // blank dups: rd_a holds item i
                  if (mstat.rd_a != '0) begin
                     j_in = i_ff + CW'(1); dupb_in = 1'b0; i_in = i_ff;
                     state_in = S_DPB;
                  end
            endcase
         end
         S_DPB: begin
            if (!dupb_ff) begin
               if (j_ff < cnt_ff) begin
                  mcmd.mop = bale_pkg::MOP_RDB; dupb_in = 1'b1;
               end else begin
                  i_in = i_ff + CW'(1); state_in = S_SRD;
               end
            end else begin
               dupb_in = 1'b0; j_in = j_ff + CW'(1);
               if (mstat.rd_b == mstat.rd_a) begin
                  mcmd.mop = bale_pkg::MOP_WRZ; mcmd.addr_a = 11'(j_ff);
               end
            end
         end
         S_UPRD:
            if (j_ff > i_ff) begin
               mcmd.mop = bale_pkg::MOP_RDA; mcmd.addr_a = 11'(j_ff - CW'(1));
               state_in = S_UPWR;
            end else state_in = S_PUT;
         S_UPWR: begin
            mcmd.mop = bale_pkg::MOP_WRA; j_in = j_ff - CW'(1); state_in = S_UPRD;
         end
         S_PUT: begin
            mcmd.mop = bale_pkg::MOP_WRV; cnt_in = cnt_ff + CW'(1); state_in = S_DONE;
         end
         S_DNRD:
            if (j_ff + CW'(1) < cnt_ff) begin
               mcmd.mop = bale_pkg::MOP_RDB; mcmd.addr_b = 11'(j_ff + CW'(1));
               state_in = S_DNWR;
            end else begin
               cnt_in = cnt_ff - CW'(1); state_in = S_DONE;
            end
         S_DNWR: begin
            mcmd.mop = bale_pkg::MOP_WRB; mcmd.addr_a = 11'(j_ff);
            j_in = j_ff + CW'(1); state_in = S_DNRD;
         end
         S_RVA:
            if (i_ff < j_ff) begin
               mcmd.mop = bale_pkg::MOP_RDA; state_in = S_RVB;
            end else state_in = S_DONE;
         S_RVB: begin mcmd.mop = bale_pkg::MOP_RDB; state_in = S_RVW; end
         S_RVW: begin mcmd.mop = bale_pkg::MOP_WRA; state_in = S_RVW2; end
         S_RVW2: begin
            mcmd.mop = bale_pkg::MOP_WRB;
            i_in = i_ff + CW'(1); j_in = j_ff - CW'(1); state_in = S_RVA;
         end
         S_DONE: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire
